// ===== rtl/hce_pkg.sv =====
// Shared constants and types for the Hill cipher encryptor core.
package hce_pkg;

    // Default largest block length (key matrix dimension).
    localparam int MAX_ORDER_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_DATA_W  = 60;
    localparam int CFG_INDEX_W = 3;
    localparam int ORDER_W     = 4;
    localparam int PACK5_W     = 20;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY4  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY5  = 3'd6;

    // Key storage: 64 entries of five bits, packed flat.
    localparam int KEY_W      = 5;
    localparam int KEY_FLAT_W = 5 * CFG_DATA_W + PACK5_W;
    localparam int KEY_BIT_W  = 9;

    // Letter arithmetic.
    localparam int             LETTER_W    = 5;
    localparam int             MOD_BASE    = 26;
    localparam logic [4:0]     PAD_VALUE   = 5'd23;
    localparam logic [6:0]     LETTER_BASE = 7'd97;
    localparam logic [7:0]     CASE_BIT    = 8'h20;
    localparam logic [7:0]     LOWER_A     = 8'd97;
    localparam logic [7:0]     LOWER_Z     = 8'd122;

    // Reciprocal of 26 scaled by 2^16, rounded down; one correction step follows.
    localparam int RECIP       = 2520;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 16;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic acc_en;   // add key * letter into the row sum
        logic first;    // first column of a row: start the sum fresh
        logic div_en;   // capture the quotient estimate of the row sum
    } mac_ctl_t;

endpackage

// ===== rtl/hill_cipher_encryptor_core.sv =====
// Hill cipher (mod 26) encryptor core: letter filter, block buffer and sequencer.
//
// Bytes arrive one word at a time on the s_ side; anything that is not an ASCII letter is
// dropped, letters are folded to lower case and collected into a block of n letters, where n
// is the order register (0 counts as 1, values above MAX_ORDER count as MAX_ORDER). A byte
// that does not complete a block is accepted at once. A byte that completes a block, or
// carries tlast with letters pending, starts encryption and holds s_tready low until the
// last cipher letter is loaded into the output register; each of the n cipher letters is
// summed over n key columns on the single shared multiply-accumulate unit, reduced mod 26;
// an m_ side stall holds the sequencer. The result sits in an output register, so the next
// byte is accepted while the final letter still waits to be taken. On tlast a partial block
// is padded with 'x'; m_tlast marks the message's final letter, and a tlast with nothing
// pending gives no output. Configuration must be written only while idle; not enforced.
module hill_cipher_encryptor_core import hce_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,   // end_of_message
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [6:0] cipher_char, [7] zero fill
    output logic                   m_tlast    // last_char
);

    localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int FILL_W = $clog2(MAX_ORDER + 1);
    localparam int KI_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int ACC_W  = $clog2(MAX_ORDER * 31 * 25 + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Configuration registers.
    logic [ORDER_W-1:0]    order_reg;
    logic [CFG_DATA_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg, key4_reg;
    logic [PACK5_W-1:0]    key5_reg;

    // Sequencer and block state.
    logic [1:0]          state_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [IDX_W-1:0]    om1_reg;
    logic [IDX_W-1:0]    row_reg;
    logic [IDX_W-1:0]    col_reg;
    logic [KI_W-1:0]     key_idx_reg;
    logic                pad_reg;
    logic                last_reg;
    logic [LETTER_W-1:0] letter_buf [MAX_ORDER];

    // Output register.
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;

    logic                  accept;
    logic [7:0]            folded;
    logic                  is_letter;
    logic                  store;
    logic [FILL_W-1:0]     fill_ins;
    logic [FILL_W-1:0]     ord_eff;
    logic [KEY_FLAT_W-1:0] key_flat;
    logic [KEY_BIT_W-1:0]  key_bit;
    logic [KEY_W-1:0]      key_entry;
    logic [LETTER_W-1:0]   cur_letter;
    logic [LETTER_W-1:0]   residue;
    logic                  out_free;
    mac_ctl_t              mac_ctl;

    // Configuration writes; unused indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_W'(1);
            key0_reg  <= '0;
            key1_reg  <= '0;
            key2_reg  <= '0;
            key3_reg  <= '0;
            key4_reg  <= '0;
            key5_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER: order_reg <= cfg_wdata[ORDER_W-1:0];
                REG_KEY0:  key0_reg  <= cfg_wdata;
                REG_KEY1:  key1_reg  <= cfg_wdata;
                REG_KEY2:  key2_reg  <= cfg_wdata;
                REG_KEY3:  key3_reg  <= cfg_wdata;
                REG_KEY4:  key4_reg  <= cfg_wdata;
                REG_KEY5:  key5_reg  <= cfg_wdata[PACK5_W-1:0];
                default:   ;
            endcase
        end
    end

    // Effective order, clamped to 1..MAX_ORDER.
    always_comb begin
        if (order_reg == '0) begin
            ord_eff = FILL_W'(1);
        end else if (32'(order_reg) > MAX_ORDER) begin
            ord_eff = FILL_W'(MAX_ORDER);
        end else begin
            ord_eff = FILL_W'(order_reg);
        end
    end

    // Letter filter and case folding.
    assign accept    = s_tvalid && s_tready;
    assign folded    = s_tdata | CASE_BIT;
    assign is_letter = (folded >= LOWER_A) && (folded <= LOWER_Z);
    assign store     = is_letter && (32'(fill_reg) < MAX_ORDER);
    assign fill_ins  = fill_reg + FILL_W'(store);

    // Key entry for the current row and column.
    assign key_flat  = {key5_reg, key4_reg, key3_reg, key2_reg, key1_reg, key0_reg};
    assign key_bit   = KEY_BIT_W'(key_idx_reg) * KEY_BIT_W'(KEY_W);
    assign key_entry = key_flat[key_bit +: KEY_W];

    // Letter of the current column, or 'x' past the end of a padded block.
    assign cur_letter = (pad_reg && (FILL_W'(col_reg) >= fill_reg)) ? PAD_VALUE
                                                                     : letter_buf[col_reg];

    assign mac_ctl.acc_en = (state_reg == ST_MAC);
    assign mac_ctl.first  = (col_reg == '0);
    assign mac_ctl.div_en = (state_reg == ST_DIV);

    hce_mac #(
        .ACC_W(ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .ctl       (mac_ctl),
        .key_entry (key_entry),
        .letter    (cur_letter),
        .residue   (residue)
    );

    assign out_free = !out_valid_reg || m_tready;

    // Block buffer write; no reset, entries are read only after being written.
    always_ff @(posedge aclk) begin
        if (accept && store) begin
            letter_buf[fill_reg[IDX_W-1:0]] <= LETTER_W'(folded - LOWER_A);
        end
    end

    // Sequencer: collect letters, then walk rows and columns of the key.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            om1_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            key_idx_reg <= '0;
            pad_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fill_reg    <= fill_ins;
                        row_reg     <= '0;
                        col_reg     <= '0;
                        key_idx_reg <= '0;
                        om1_reg     <= IDX_W'(ord_eff - FILL_W'(1));
                        if (s_tlast) begin
                            pad_reg  <= 1'b1;
                            last_reg <= 1'b1;
                            if (fill_ins != '0) begin
                                state_reg <= ST_MAC;
                            end
                        end else if (fill_ins >= ord_eff) begin
                            pad_reg   <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_MAC: begin
                    key_idx_reg <= key_idx_reg + KI_W'(1);
                    if (col_reg == om1_reg) begin
                        state_reg <= ST_DIV;
                    end else begin
                        col_reg <= col_reg + IDX_W'(1);
                    end
                end
                ST_DIV: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        col_reg <= '0;
                        if (row_reg == om1_reg) begin
                            fill_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            row_reg   <= row_reg + IDX_W'(1);
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: loaded with each reduced row sum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            out_char_reg <= LETTER_BASE + 7'(residue);
            out_last_reg <= last_reg && (row_reg == om1_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // The letter count never passes the buffer depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= MAX_ORDER)
        else $error("fill count beyond buffer depth");

    // The column walk stays inside the block in use.
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (col_reg <= om1_reg))
        else $error("column index past block length");

    // Every cipher word is a lower-case letter.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[6:0] >= LETTER_BASE) && (m_tdata[6:0] <= 7'(LOWER_Z))))
        else $error("cipher word outside a..z");

    // Once the final letter of a block is loaded, the buffer is empty and input reopens.
    a_block_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && out_free && (row_reg == om1_reg))
        |=> ((fill_reg == '0) && s_tready))
        else $error("block not released after final letter");

endmodule

// ===== rtl/hce_mac.sv =====
// Shared multiply-accumulate unit with mod-26 reduction of the row sum.
module hce_mac import hce_pkg::*; #(
    parameter int ACC_W = 13
) (
    input  logic                aclk,
    input  mac_ctl_t            ctl,
    input  logic [KEY_W-1:0]    key_entry,
    input  logic [LETTER_W-1:0] letter,
    output logic [LETTER_W-1:0] residue
);

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         quot_reg;
    logic [ACC_W-1:0]         quot_next;
    logic [KEY_W+LETTER_W-1:0] prod;
    logic [ACC_W+RECIP_W-1:0] recip_prod;
    logic [ACC_W-1:0]         rem_raw;
    logic [ACC_W-1:0]         rem_fix;

    // One product per cycle while acc_en is set, summed into the running row sum.
    assign prod     = key_entry * letter;
    assign acc_next = (ctl.first ? '0 : acc_reg) + ACC_W'(prod);

    // Quotient estimate by reciprocal multiplication; may fall short by one.
    assign recip_prod = (ACC_W+RECIP_W)'(acc_reg) * (ACC_W+RECIP_W)'(RECIP);
    assign quot_next  = ACC_W'(recip_prod >> RECIP_SHIFT);

    always_ff @(posedge aclk) begin
        if (ctl.acc_en) begin
            acc_reg <= acc_next;
        end
        if (ctl.div_en) begin
            quot_reg <= quot_next;
        end
    end

    // Remainder with a single correction step.
    always_comb begin
        rem_raw = acc_reg - quot_reg * ACC_W'(MOD_BASE);
        if (rem_raw >= ACC_W'(MOD_BASE)) begin
            rem_fix = rem_raw - ACC_W'(MOD_BASE);
        end else begin
            rem_fix = rem_raw;
        end
    end

    assign residue = LETTER_W'(rem_fix);

endmodule
